// ===== rtl/mtse_pkg.sv =====
// shared types, request and status codes and arithmetic helpers
// for the model transform stack engine; no dependencies
package mtse_pkg;

  localparam logic [2:0] REQ_TRANSLATE = 3'd0;
  localparam logic [2:0] REQ_SCALE     = 3'd1;
  localparam logic [2:0] REQ_ROTATE    = 3'd2;
  localparam logic [2:0] REQ_PUSH      = 3'd3;
  localparam logic [2:0] REQ_POP       = 3'd4;
  localparam logic [2:0] REQ_POINT     = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic [32:0]        TWO_PI_U    = 33'd6746518852;

  typedef logic signed [31:0] fx_t;

  typedef struct packed {
    logic sat;
    fx_t  v;
  } fx_sat_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [3:0] tag;
  } mac_req_t;

  typedef struct packed {
    logic       valid;
    logic       sat;
    logic [3:0] tag;
  } mac_rsp_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 32'h3243F6A8;
      5'd1:  atan_q30 = 32'h1DAC6705;
      5'd2:  atan_q30 = 32'h0FADBAFC;
      5'd3:  atan_q30 = 32'h07F56EA6;
      5'd4:  atan_q30 = 32'h03FEAB76;
      5'd5:  atan_q30 = 32'h01FFD55B;
      5'd6:  atan_q30 = 32'h00FFFAAA;
      5'd7:  atan_q30 = 32'h007FFF55;
      5'd8:  atan_q30 = 32'h003FFFEA;
      5'd9:  atan_q30 = 32'h001FFFFD;
      5'd10: atan_q30 = 32'h000FFFFF;
      5'd11: atan_q30 = 32'h0007FFFF;
      5'd12: atan_q30 = 32'h0003FFFF;
      5'd13: atan_q30 = 32'h0001FFFF;
      5'd14: atan_q30 = 32'h0000FFFF;
      5'd15: atan_q30 = 32'h00007FFF;
      5'd16: atan_q30 = 32'h00003FFF;
      5'd17: atan_q30 = 32'h00001FFF;
      5'd18: atan_q30 = 32'h00000FFF;
      5'd19: atan_q30 = 32'h000007FF;
      5'd20: atan_q30 = 32'h000003FF;
      5'd21: atan_q30 = 32'h000001FF;
      5'd22: atan_q30 = 32'h000000FF;
      5'd23: atan_q30 = 32'h0000007F;
      5'd24: atan_q30 = 32'h0000003F;
      5'd25: atan_q30 = 32'h0000001F;
      5'd26: atan_q30 = 32'h0000000F;
      5'd27: atan_q30 = 32'h00000008;
      5'd28: atan_q30 = 32'h00000004;
      5'd29: atan_q30 = 32'h00000002;
      default: atan_q30 = 32'h00000000;
    endcase
  endfunction

  function automatic fx_sat_t sat36(input logic signed [35:0] v);
    fx_sat_t r;
    if (v > 36'sh07FFFFFFF) begin
      r.sat = 1'b1;
      r.v   = 32'sh7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      r.sat = 1'b1;
      r.v   = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.v   = v[31:0];
    end
    return r;
  endfunction

  function automatic fx_sat_t sat_add(input fx_t a, input fx_t b);
    return sat36(36'(a) + 36'(b));
  endfunction

  function automatic fx_sat_t sat_neg(input fx_t a);
    return sat36(-36'(a));
  endfunction

endpackage

// ===== rtl/model_transform_stack_engine.sv =====
// matrix transform engine: 4x4 current matrix, matrix stack, point transform
// rotate runs (30 - FRAC_BITS) angle reduction steps, 30 cordic steps, the rotation terms
// and then the matrix product; a point skips the divide by w when w is zero;
// one item at a time, set by the single shared multiplier, the cordic loop and the bit-serial divider
// rst_n loads identity and empties the stack
module model_transform_stack_engine #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // val_x, val_y, val_z, angle
  input  logic [2:0]   in_tuser,  // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata, // out_x, out_y, out_z
  output logic [1:0]   out_tuser  // status
);
  import mtse_pkg::*;

  localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ADDR_W  = $clog2(STACK_DEPTH * 16);
  localparam int AW      = 62 - FRAC_BITS;
  localparam int RED_TOP = AW - 33;
  localparam fx_t ONE_FX = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [35:0] CS_HALF = 36'sd1 <<< (29 - FRAC_BITS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RED   = 5'd1;
  localparam logic [4:0] S_FOLD1 = 5'd2;
  localparam logic [4:0] S_FOLD2 = 5'd3;
  localparam logic [4:0] S_CORD  = 5'd4;
  localparam logic [4:0] S_CSRND = 5'd5;
  localparam logic [4:0] S_C1    = 5'd6;
  localparam logic [4:0] S_ROT1  = 5'd7;
  localparam logic [4:0] S_ROT2  = 5'd8;
  localparam logic [4:0] S_ROTT  = 5'd9;
  localparam logic [4:0] S_MM    = 5'd10;
  localparam logic [4:0] S_PT    = 5'd11;
  localparam logic [4:0] S_DRAIN = 5'd12;
  localparam logic [4:0] S_WCHK  = 5'd13;
  localparam logic [4:0] S_DIV   = 5'd14;
  localparam logic [4:0] S_PUSH  = 5'd15;
  localparam logic [4:0] S_POP   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  localparam logic [1:0] WB_CUR = 2'd0;
  localparam logic [1:0] WB_VEC = 2'd1;
  localparam logic [1:0] WB_RS  = 2'd2;
  localparam logic [1:0] WB_PR  = 2'd3;

  logic [4:0]       state_r;
  logic [4:0]       ret_r;
  logic [5:0]       cnt_r;
  logic [1:0]       wb_r;
  logic [LVL_W-1:0] lvl_r;
  logic [1:0]       status_r;
  logic             sat_r;
  logic             dgo_r;
  logic             out_valid_r;
  fx_t              cur_r [16];
  fx_t              t_r [16];
  fx_t              p_r [4];
  fx_t              row_r [4];
  fx_t              v_r [4];
  fx_t              rs_r [4];
  fx_t              pr_r [4][3];
  fx_t              o_r [3];
  fx_t              cs_r;
  fx_t              c1_r;
  logic [AW-1:0]    mag_r;
  logic             aneg_r;
  logic             cneg_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [34:0] z_r;

  logic [3:0]       cur_ridx;
  fx_t              cur_rd;
  mac_req_t         mac_req;
  mac_rsp_t         mac_rsp;
  fx_t              mac_a;
  fx_t              mac_b;
  fx_t              mac_res;
  logic             mac_busy;
  logic             div_start;
  logic             div_done;
  fx_t              div_quo;
  logic             div_sat;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]      ram_rdata;
  logic [1:0]       mm_i;
  logic [1:0]       mm_j;
  logic [1:0]       mm_k;
  logic             in_xfer;
  fx_t              in_x;
  fx_t              in_y;
  fx_t              in_z;
  fx_t              in_ang;
  logic [31:0]      ang_abs;
  logic [AW-1:0]    red_c;
  logic signed [34:0] r_fold;
  logic signed [33:0] cd_dx;
  logic signed [33:0] cd_dy;
  logic signed [34:0] cd_at;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  fx_sat_t          cs_s;
  fx_sat_t          sn_s;
  fx_sat_t          c1_s;
  fx_sat_t          n1;
  fx_sat_t          n6;
  fx_sat_t          n8;
  fx_sat_t          e0;
  fx_sat_t          e1;
  fx_sat_t          e2;
  fx_sat_t          e4;
  fx_sat_t          e5;
  fx_sat_t          e6;
  fx_sat_t          e8;
  fx_sat_t          e9;
  fx_sat_t          e10;
  logic             rot_sat;
  logic [1:0]       status_fin;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign in_x      = in_tdata[31:0];
  assign in_y      = in_tdata[63:32];
  assign in_z      = in_tdata[95:64];
  assign in_ang    = in_tdata[127:96];
  assign ang_abs   = in_ang[31] ? (~in_ang + 32'd1) : in_ang;

  assign mm_i   = cnt_r[5:4];
  assign mm_j   = cnt_r[3:2];
  assign mm_k   = cnt_r[1:0];
  assign cur_rd = cur_r[cur_ridx];

  // angle reduction, fold and cordic datapath
  assign red_c  = AW'(TWO_PI_U) << cnt_r;
  assign r_fold = aneg_r ? -$signed({2'b00, mag_r[32:0]}) : $signed({2'b00, mag_r[32:0]});
  assign cd_dx  = y_r >>> cnt_r[4:0];
  assign cd_dy  = x_r >>> cnt_r[4:0];
  assign cd_at  = $signed({3'b000, atan_q30(cnt_r[4:0])});
  assign xs     = cneg_r ? -36'(x_r) : 36'(x_r);
  assign ys     = cneg_r ? -36'(y_r) : 36'(y_r);
  assign cs_s   = sat36((xs + CS_HALF) >>> (30 - FRAC_BITS));
  assign sn_s   = sat36((ys + CS_HALF) >>> (30 - FRAC_BITS));
  assign c1_s   = sat36(36'(ONE_FX) - 36'(cs_r));

  // rotation matrix terms, rs holds tx, ty, tz, sin
  assign n1  = sat_neg(pr_r[3][2]);
  assign n6  = sat_neg(pr_r[3][0]);
  assign n8  = sat_neg(pr_r[3][1]);
  assign e0  = sat_add(cs_r, pr_r[0][0]);
  assign e1  = sat_add(pr_r[0][1], n1.v);
  assign e2  = sat_add(pr_r[0][2], pr_r[3][1]);
  assign e4  = sat_add(pr_r[1][0], pr_r[3][2]);
  assign e5  = sat_add(cs_r, pr_r[1][1]);
  assign e6  = sat_add(pr_r[1][2], n6.v);
  assign e8  = sat_add(pr_r[2][0], n8.v);
  assign e9  = sat_add(pr_r[2][1], pr_r[3][0]);
  assign e10 = sat_add(cs_r, pr_r[2][2]);
  assign rot_sat = n1.sat | n6.sat | n8.sat | e0.sat | e1.sat | e2.sat | e4.sat |
                   e5.sat | e6.sat | e8.sat | e9.sat | e10.sat;

  // operand select for the shared multiplier
  always_comb begin
    mac_req  = '0;
    mac_a    = '0;
    mac_b    = '0;
    cur_ridx = cnt_r[3:0];
    case (state_r)
      S_MM: begin
        cur_ridx = {mm_i, mm_k};
        mac_a    = (mm_j == 2'd0) ? cur_rd : row_r[mm_k];
        mac_b    = t_r[{mm_k, mm_j}];
        mac_req  = '{valid: 1'b1, first: mm_k == 2'd0, last: mm_k == 2'd3,
                     tag: {mm_i, mm_j}};
      end
      S_PT: begin
        mac_a   = cur_rd;
        mac_b   = p_r[cnt_r[1:0]];
        mac_req = '{valid: 1'b1, first: cnt_r[1:0] == 2'd0, last: cnt_r[1:0] == 2'd3,
                    tag: {2'b00, cnt_r[3:2]}};
      end
      S_ROT1: begin
        mac_a   = c1_r;
        mac_b   = p_r[cnt_r[1:0]];
        mac_req = '{valid: 1'b1, first: 1'b1, last: 1'b1, tag: {2'b00, cnt_r[1:0]}};
      end
      S_ROT2: begin
        mac_a   = rs_r[cnt_r[3:2]];
        mac_b   = p_r[cnt_r[1:0]];
        mac_req = '{valid: cnt_r[1:0] != 2'd3, first: 1'b1, last: 1'b1, tag: cnt_r[3:0]};
      end
      default: begin
        mac_req = '0;
      end
    endcase
  end

  assign div_start = (state_r == S_DIV) && !dgo_r;
  assign ram_we    = (state_r == S_PUSH);
  always_comb begin
    if (state_r == S_POP) begin
      ram_addr = ADDR_W'({IDX_W'(lvl_r - LVL_W'(1)), cnt_r[3:0]});
    end else begin
      ram_addr = ADDR_W'({IDX_W'(lvl_r), cnt_r[3:0]});
    end
  end

  assign status_fin = (status_r != ST_OK) ? status_r : (sat_r ? ST_SAT : ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      wb_r        <= WB_CUR;
      lvl_r       <= '0;
      status_r    <= ST_OK;
      sat_r       <= 1'b0;
      dgo_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int e = 0; e < 16; e++) begin
        cur_r[e] <= ((e % 5) == 0) ? ONE_FX : 32'sd0;
      end
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (mac_rsp.valid) begin
        sat_r <= sat_r | mac_rsp.sat;
        case (wb_r)
          WB_CUR:  cur_r[mac_rsp.tag] <= mac_res;
          WB_VEC:  v_r[mac_rsp.tag[1:0]] <= mac_res;
          WB_RS:   rs_r[mac_rsp.tag[1:0]] <= mac_res;
          default: pr_r[mac_rsp.tag[3:2]][mac_rsp.tag[1:0]] <= mac_res;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            status_r <= ST_OK;
            sat_r    <= 1'b0;
            cnt_r    <= '0;
            o_r[0]   <= '0;
            o_r[1]   <= '0;
            o_r[2]   <= '0;
            p_r[0]   <= in_x;
            p_r[1]   <= in_y;
            p_r[2]   <= in_z;
            p_r[3]   <= ONE_FX;
            for (int e = 0; e < 16; e++) begin
              t_r[e] <= ((e % 5) == 0) ? ONE_FX : 32'sd0;
            end
            case (in_tuser)
              REQ_TRANSLATE: begin
                t_r[3]  <= in_x;
                t_r[7]  <= in_y;
                t_r[11] <= in_z;
                state_r <= S_MM;
              end
              REQ_SCALE: begin
                t_r[0]  <= in_x;
                t_r[5]  <= in_y;
                t_r[10] <= in_z;
                state_r <= S_MM;
              end
              REQ_ROTATE: begin
                mag_r   <= AW'(ang_abs) << (30 - FRAC_BITS);
                aneg_r  <= in_ang[31];
                cnt_r   <= 6'(RED_TOP);
                state_r <= S_RED;
              end
              REQ_PUSH: begin
                if (lvl_r == LVL_W'(STACK_DEPTH)) begin
                  status_r <= ST_PUSH_FULL;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_PUSH;
                end
              end
              REQ_POP: begin
                if (lvl_r == '0) begin
                  status_r <= ST_POP_EMPTY;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_POP;
                end
              end
              REQ_POINT: begin
                state_r <= S_PT;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_RED: begin
          if (mag_r >= red_c) begin
            mag_r <= mag_r - red_c;
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            state_r <= S_FOLD1;
          end
        end
        S_FOLD1: begin
          if (r_fold >= PI_Q30) begin
            z_r <= r_fold - TWO_PI_Q30;
          end else if (r_fold < -PI_Q30) begin
            z_r <= r_fold + TWO_PI_Q30;
          end else begin
            z_r <= r_fold;
          end
          state_r <= S_FOLD2;
        end
        S_FOLD2: begin
          if (z_r > HALF_PI_Q30) begin
            z_r    <= z_r - PI_Q30;
            cneg_r <= 1'b1;
          end else if (z_r < -HALF_PI_Q30) begin
            z_r    <= z_r + PI_Q30;
            cneg_r <= 1'b1;
          end else begin
            cneg_r <= 1'b0;
          end
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          cnt_r   <= '0;
          state_r <= S_CORD;
        end
        S_CORD: begin
          if (!z_r[34]) begin
            x_r <= x_r - cd_dx;
            y_r <= y_r + cd_dy;
            z_r <= z_r - cd_at;
          end else begin
            x_r <= x_r + cd_dx;
            y_r <= y_r - cd_dy;
            z_r <= z_r + cd_at;
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
            state_r <= S_CSRND;
          end
        end
        S_CSRND: begin
          cs_r    <= cs_s.v;
          rs_r[3] <= sn_s.v;
          sat_r   <= sat_r | cs_s.sat | sn_s.sat;
          state_r <= S_C1;
        end
        S_C1: begin
          c1_r    <= c1_s.v;
          sat_r   <= sat_r | c1_s.sat;
          cnt_r   <= '0;
          state_r <= S_ROT1;
        end
        S_ROT1: begin
          wb_r  <= WB_RS;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd2) begin
            ret_r   <= S_ROT2;
            state_r <= S_DRAIN;
          end
        end
        S_ROT2: begin
          wb_r  <= WB_PR;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) begin
            ret_r   <= S_ROTT;
            state_r <= S_DRAIN;
          end
        end
        S_ROTT: begin
          t_r[0]  <= e0.v;
          t_r[1]  <= e1.v;
          t_r[2]  <= e2.v;
          t_r[4]  <= e4.v;
          t_r[5]  <= e5.v;
          t_r[6]  <= e6.v;
          t_r[8]  <= e8.v;
          t_r[9]  <= e9.v;
          t_r[10] <= e10.v;
          sat_r   <= sat_r | rot_sat;
          cnt_r   <= '0;
          state_r <= S_MM;
        end
        S_MM: begin
          wb_r <= WB_CUR;
          if (mm_j == 2'd0) begin
            row_r[mm_k] <= cur_rd;
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            ret_r   <= S_DONE;
            state_r <= S_DRAIN;
          end
        end
        S_PT: begin
          wb_r  <= WB_VEC;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) begin
            ret_r   <= S_WCHK;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            cnt_r   <= '0;
            state_r <= ret_r;
          end
        end
        S_WCHK: begin
          dgo_r <= 1'b0;
          cnt_r <= '0;
          if (v_r[3] == '0) begin
            sat_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_start) begin
            dgo_r <= 1'b1;
          end
          if (div_done) begin
            o_r[cnt_r[1:0]] <= div_quo;
            sat_r           <= sat_r | div_sat;
            dgo_r           <= 1'b0;
            cnt_r           <= cnt_r + 6'd1;
            if (cnt_r == 6'd2) begin
              state_r <= S_DONE;
            end
          end
        end
        S_PUSH: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) begin
            lvl_r   <= lvl_r + LVL_W'(1);
            state_r <= S_DONE;
          end
        end
        S_POP: begin
          if (cnt_r != '0) begin
            cur_r[4'(cnt_r - 6'd1)] <= ram_rdata;
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd16) begin
            lvl_r   <= lvl_r - LVL_W'(1);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tdata   <= {o_r[2], o_r[1], o_r[0]};
            out_tuser   <= status_fin;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

  mtse_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mac_req),
    .a    (mac_a),
    .b    (mac_b),
    .rsp  (mac_rsp),
    .res  (mac_res),
    .busy (mac_busy)
  );

  mtse_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (v_r[cnt_r[1:0]]),
    .den  (v_r[3]),
    .done (div_done),
    .quo  (div_quo),
    .sat  (div_sat)
  );

  mtse_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH * 16)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(cur_rd),
    .rdata(ram_rdata)
  );

`ifndef ASSERT_OFF
  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !mac_busy)
    else $error("transfer accepted while multiplier busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_wb_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mac_rsp.valid |-> (state_r == S_MM || state_r == S_PT || state_r == S_ROT1 ||
                       state_r == S_ROT2 || state_r == S_DRAIN))
    else $error("multiplier result outside issue or drain");
`endif

endmodule

// ===== rtl/mtse_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module mtse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/mtse_mac.sv =====
// pipelined multiply-accumulate with round to nearest and saturation
// depends on mtse_pkg
module mtse_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mtse_pkg::mac_req_t req,
  input  mtse_pkg::fx_t      a,
  input  mtse_pkg::fx_t      b,
  output mtse_pkg::mac_rsp_t rsp,
  output mtse_pkg::fx_t      res,
  output logic               busy
);
  import mtse_pkg::*;

  localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);

  mac_req_t          s1_r;
  mac_req_t          s2_r;
  mac_rsp_t          s3_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [65:0] acc_nxt;
  logic signed [65:0] rnd;
  fx_t               res_r;

  assign acc_nxt = (s1_r.first ? 66'sd0 : acc_r) + 66'(prod_r);
  assign rnd     = (acc_r + RND_HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else begin
      s1_r       <= req;
      s2_r       <= '{valid: s1_r.valid & s1_r.last, first: s1_r.first, last: s1_r.last,
                      tag: s1_r.tag};
      s3_r.valid <= s2_r.valid;
      s3_r.tag   <= s2_r.tag;
      s3_r.sat   <= (rnd > 66'sh07FFFFFFF) || (rnd < -66'sh080000000);
    end
    prod_r <= 64'(a) * 64'(b);
    if (s1_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (rnd > 66'sh07FFFFFFF) begin
      res_r <= 32'sh7FFFFFFF;
    end else if (rnd < -66'sh080000000) begin
      res_r <= 32'sh80000000;
    end else begin
      res_r <= rnd[31:0];
    end
  end

  assign rsp  = s3_r;
  assign res  = res_r;
  assign busy = s1_r.valid | s2_r.valid | s3_r.valid;

endmodule

// ===== rtl/mtse_div.sv =====
// radix-2 restoring divider for the divide by w, rounded half away from zero
// depends on mtse_pkg
module mtse_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mtse_pkg::fx_t num,
  input  mtse_pkg::fx_t den,
  output logic          done,
  output mtse_pkg::fx_t quo,
  output logic          sat
);
  import mtse_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [31:0]   den_r;
  logic [31:0]   rem_r;
  logic [31:0]   num_abs;
  logic [31:0]   den_abs;
  logic [32:0]   trial;
  logic          qbit;

  assign num_abs = num[31] ? (~num + 32'd1) : num;
  assign den_abs = den[31] ? (~den + 32'd1) : den;
  assign trial   = {rem_r, dvd_r[DW-1]};
  assign qbit    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      dvd_r <= (DW'(num_abs) << FRAC_BITS) + DW'(den_abs >> 1);
      den_r <= den_abs;
      neg_r <= num[31] ^ den[31];
      rem_r <= '0;
      cnt_r <= CW'(DW);
    end else if (busy_r) begin
      rem_r <= qbit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      dvd_r <= {dvd_r[DW-2:0], qbit};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_comb begin
    sat = 1'b0;
    if (neg_r) begin
      if (dvd_r > DW'(33'h080000000)) begin
        sat = 1'b1;
        quo = 32'sh80000000;
      end else begin
        quo = 32'd0 - dvd_r[31:0];
      end
    end else begin
      if (dvd_r > DW'(32'h7FFFFFFF)) begin
        sat = 1'b1;
        quo = 32'sh7FFFFFFF;
      end else begin
        quo = dvd_r[31:0];
      end
    end
  end

  assign done = done_r;

endmodule

// ===== tb/model_transform_stack_engine_tb.sv =====
// self-checking testbench for model_transform_stack_engine: a bit-exact predictor of the
// matrix stack, fixed-point products, cordic rotation and divide by w; depends on
// rtl/mtse_pkg.sv and rtl/model_transform_stack_engine.sv
`timescale 1ns / 100ps

module model_transform_stack_engine_tb;
  import mtse_pkg::*;

  localparam int DEPTH = 16;
  localparam int FB = 16;
  localparam fx_t ONE = 32'sd1 <<< FB;
  localparam int NUM_RANDOM = 680;

  typedef struct {
    logic [2:0] req;
    fx_t        x, y, z, ang;
  } xform_req_t;

  typedef struct {
    fx_t        x, y, z;
    logic [1:0] st;
  } xform_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  xform_req_t pending_reqs[$];
  xform_res_t expected_res[$];
  fx_t        cur_mat[16];
  fx_t        saved_mat[DEPTH][16];
  int         stack_lvl;
  bit         sat_seen;
  int         fail_cnt;
  int         n_checked;
  int         n_points;
  int         n_sat;
  int         in_gap;
  int         out_stall;

  model_transform_stack_engine #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FB)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic fx_t clamp_fx(input logic signed [67:0] v);
    if (v > 68'sh7FFFFFFF) begin
      sat_seen = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -68'sh80000000) begin
      sat_seen = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic fx_t add_fx(input fx_t a, input fx_t b);
    return clamp_fx(68'(a) + 68'(b));
  endfunction

  function automatic fx_t neg_fx(input fx_t a);
    return clamp_fx(-68'(a));
  endfunction

  function automatic fx_t mul_round(input fx_t a, input fx_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + (68'sd1 <<< (FB - 1));
    return clamp_fx(p >>> FB);
  endfunction

  function automatic fx_t dot_round(input fx_t a[4], input fx_t b[4]);
    logic signed [67:0] acc;
    acc = 68'sd1 <<< (FB - 1);
    for (int k = 0; k < 4; k++) acc += 68'(a[k]) * 68'(b[k]);
    return clamp_fx(acc >>> FB);
  endfunction

  function automatic void mat_right_mul(input fx_t t[16]);
    fx_t prod[16];
    fx_t row[4];
    fx_t col[4];
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) row[k] = cur_mat[i*4+k];
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) col[k] = t[k*4+j];
        prod[i*4+j] = dot_round(row, col);
      end
    end
    cur_mat = prod;
  endfunction

  function automatic void cordic_sin_cos(input fx_t ang, output fx_t sn, output fx_t cs);
    longint r, x, y, z, dx, dy, half, pi_v, hpi_v;
    bit flip;
    pi_v = PI_Q30;
    hpi_v = HALF_PI_Q30;
    half = 64'sd1 << (29 - FB);
    r = (longint'(ang) * (64'sd1 << (30 - FB))) % (2 * pi_v);
    flip = 1'b0;
    if (r >= pi_v) r -= 2 * pi_v;
    else if (r < -pi_v) r += 2 * pi_v;
    if (r > hpi_v) begin
      r -= pi_v;
      flip = 1'b1;
    end else if (r < -hpi_v) begin
      r += pi_v;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = clamp_fx(68'((x + half) >>> (30 - FB)));
    sn = clamp_fx(68'((y + half) >>> (30 - FB)));
  endfunction

  function automatic fx_t div_by_w(input fx_t v, input fx_t w);
    longint num;
    longint unsigned un, uw, q;
    num = longint'(v) * ONE;
    un = (num < 0) ? longint'(-num) : num;
    uw = (w < 0) ? -longint'(w) : longint'(w);
    q = (un + uw / 2) / uw;
    if ((num < 0) != (w < 0)) begin
      if (q > 64'h80000000) begin
        sat_seen = 1'b1;
        return 32'sh80000000;
      end
      return fx_t'(-longint'(q));
    end
    if (q > 64'h7FFFFFFF) begin
      sat_seen = 1'b1;
      return 32'sh7FFFFFFF;
    end
    return fx_t'(q);
  endfunction

  function automatic xform_res_t predict_xform(input xform_req_t rq);
    xform_res_t res;
    fx_t t[16];
    fx_t sn, cs, c1, tx, ty, tz;
    fx_t p[4], row[4], v[4];
    res = '{x: 0, y: 0, z: 0, st: ST_OK};
    sat_seen = 1'b0;
    foreach (t[i]) t[i] = 0;
    case (rq.req)
      REQ_TRANSLATE: begin
        t[0] = ONE; t[5] = ONE; t[10] = ONE; t[15] = ONE;
        t[3] = rq.x; t[7] = rq.y; t[11] = rq.z;
        mat_right_mul(t);
      end
      REQ_SCALE: begin
        t[0] = rq.x; t[5] = rq.y; t[10] = rq.z; t[15] = ONE;
        mat_right_mul(t);
      end
      REQ_ROTATE: begin
        cordic_sin_cos(rq.ang, sn, cs);
        c1 = add_fx(ONE, -cs);
        tx = mul_round(c1, rq.x);
        ty = mul_round(c1, rq.y);
        tz = mul_round(c1, rq.z);
        t[0] = add_fx(cs, mul_round(tx, rq.x));
        t[1] = add_fx(mul_round(tx, rq.y), neg_fx(mul_round(sn, rq.z)));
        t[2] = add_fx(mul_round(tx, rq.z), mul_round(sn, rq.y));
        t[4] = add_fx(mul_round(ty, rq.x), mul_round(sn, rq.z));
        t[5] = add_fx(cs, mul_round(ty, rq.y));
        t[6] = add_fx(mul_round(ty, rq.z), neg_fx(mul_round(sn, rq.x)));
        t[8] = add_fx(mul_round(tz, rq.x), neg_fx(mul_round(sn, rq.y)));
        t[9] = add_fx(mul_round(tz, rq.y), mul_round(sn, rq.x));
        t[10] = add_fx(cs, mul_round(tz, rq.z));
        t[15] = ONE;
        mat_right_mul(t);
      end
      REQ_PUSH: begin
        if (stack_lvl >= DEPTH) begin
          res.st = ST_PUSH_FULL;
        end else begin
          saved_mat[stack_lvl] = cur_mat;
          stack_lvl++;
        end
      end
      REQ_POP: begin
        if (stack_lvl == 0) begin
          res.st = ST_POP_EMPTY;
        end else begin
          stack_lvl--;
          cur_mat = saved_mat[stack_lvl];
        end
      end
      REQ_POINT: begin
        p[0] = rq.x; p[1] = rq.y; p[2] = rq.z; p[3] = ONE;
        for (int i = 0; i < 4; i++) begin
          for (int k = 0; k < 4; k++) row[k] = cur_mat[i*4+k];
          v[i] = dot_round(row, p);
        end
        if (v[3] == 0) begin
          sat_seen = 1'b1;
        end else begin
          res.x = div_by_w(v[0], v[3]);
          res.y = div_by_w(v[1], v[3]);
          res.z = div_by_w(v[2], v[3]);
        end
      end
      default: ;
    endcase
    if (res.st == ST_OK && sat_seen) res.st = ST_SAT;
    return res;
  endfunction

  function automatic fx_t rand_full();
    return fx_t'($urandom);
  endfunction

  // signed value within +-range (whole units), fractional bits random
  function automatic fx_t rand_near(input int range);
    return fx_t'(int'($urandom_range(0, 2 * range * ONE)) - range * int'(ONE));
  endfunction

  function automatic void add_req(input logic [2:0] req, input fx_t x, input fx_t y,
                                  input fx_t z, input fx_t ang);
    xform_req_t rq;
    rq = '{req: req, x: x, y: y, z: z, ang: ang};
    pending_reqs.insert(pending_reqs.size(), rq);
  endfunction

  function automatic void add_xform_rand();
    fx_t sf[3];
    case ($urandom_range(0, 2))
      0: add_req(REQ_TRANSLATE, rand_near(50), rand_near(50), rand_near(50), rand_full());
      1: begin
        foreach (sf[i]) begin
          sf[i] = fx_t'($urandom_range(ONE / 4, 2 * ONE));
          if ($urandom_range(0, 3) == 0) sf[i] = -sf[i];
        end
        add_req(REQ_SCALE, sf[0], sf[1], sf[2], rand_full());
      end
      default: add_req(REQ_ROTATE, rand_near(1), rand_near(1), rand_near(1),
                       ($urandom_range(0, 4) == 0) ? rand_full() : rand_near(10));
    endcase
  endfunction

  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: one nonblocking update of tvalid per edge
  always @(posedge clk) begin
    xform_req_t rq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        rq.req = in_tuser;
        rq.x = in_tdata[31:0];
        rq.y = in_tdata[63:32];
        rq.z = in_tdata[95:64];
        rq.ang = in_tdata[127:96];
        expected_res.insert(expected_res.size(), predict_xform(rq));
        if (rq.req == REQ_POINT) n_points++;
      end
      if (in_gap > 0 || pending_reqs.size() == 0) begin
        in_tvalid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        rq = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= rq.req;
        in_tdata  <= {rq.ang, rq.z, rq.y, rq.x};
        in_gap    <= pick_delay();
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    xform_res_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h status=%0d", $time,
                   out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser);
          fail_cnt++;
        end else begin
          exp_r = expected_res.pop_front();
          n_checked++;
          if (exp_r.st == ST_SAT) n_sat++;
          if (out_tdata[31:0] !== exp_r.x)
            $display("%0t: out_x expected %h actual %h", $time, exp_r.x, out_tdata[31:0]);
          if (out_tdata[63:32] !== exp_r.y)
            $display("%0t: out_y expected %h actual %h", $time, exp_r.y, out_tdata[63:32]);
          if (out_tdata[95:64] !== exp_r.z)
            $display("%0t: out_z expected %h actual %h", $time, exp_r.z, out_tdata[95:64]);
          if (out_tuser !== exp_r.st)
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, out_tuser);
          if (out_tdata !== {exp_r.z, exp_r.y, exp_r.x} || out_tuser !== exp_r.st)
            fail_cnt++;
        end
      end
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall  <= out_stall - 1;
      end else begin
        out_tready <= 1'b1;
        out_stall  <= ($urandom_range(0, 2) == 0) ? pick_delay() : 0;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    fail_cnt = 0;
    n_checked = 0;
    n_points = 0;
    n_sat = 0;
    stack_lvl = 0;
    foreach (cur_mat[i]) cur_mat[i] = (i % 5 == 0) ? fx_t'(ONE) : 0;

    // directed part
    add_req(REQ_POP, 0, 0, 0, 0);
    add_req(REQ_POINT, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00018000, 0);
    add_req(REQ_PUSH, 0, 0, 0, 0);
    add_req(REQ_TRANSLATE, 32'sh7FFFFFFF, 32'sh80000000, 32'shFFFFFFFF, 32'sh7FFFFFFF);
    add_req(REQ_POINT, 32'sh00010000, 32'shFFFF0000, 32'sh7FFFFFFF, 0);
    add_req(REQ_POP, 0, 0, 0, 0);
    add_req(REQ_PUSH, 0, 0, 0, 0);
    add_req(REQ_SCALE, 32'sh00020000, 32'sh00008000, 32'shFFFF0000, 0);
    add_req(REQ_ROTATE, 0, 0, 32'sh00010000, 32'sh0001921F);
    add_req(REQ_ROTATE, 32'sh00010000, 32'sh00010000, 0, 32'sh80000000);
    add_req(REQ_ROTATE, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_req(REQ_POINT, 32'sh00030000, 32'shFFFE8000, 32'sh00001234, 0);
    add_req(3'd6, 32'sh12345678, 0, 0, 0);
    add_req(3'd7, 0, 32'shFFFFFFFF, 0, 0);
    add_req(REQ_POP, 0, 0, 0, 0);
    add_req(REQ_ROTATE, 0, 32'sh00010000, 0, 32'shFFFCDBC1);
    add_req(REQ_POINT, 32'sh00010000, 32'sh00020000, 32'sh00030000, 0);
    add_req(REQ_SCALE, 0, 0, 0, 0);
    add_req(REQ_POINT, 32'sh00050000, 32'sh00050000, 32'sh00050000, 0);
    // fill the stack past its depth, then drain it past empty
    for (int i = 0; i <= DEPTH; i++) add_req(REQ_PUSH, 0, 0, 0, 0);
    for (int i = 0; i <= DEPTH; i++) add_req(REQ_POP, 0, 0, 0, 0);

    // random part: mostly push / transforms / points / pop groups, some noise
    while (pending_reqs.size() < NUM_RANDOM + 60) begin
      if ($urandom_range(0, 9) == 0) begin
        add_req(3'($urandom_range(0, 7)), rand_full(), rand_full(), rand_full(),
                rand_full());
      end else begin
        add_req(REQ_PUSH, 0, 0, 0, 0);
        repeat ($urandom_range(1, 3)) add_xform_rand();
        repeat ($urandom_range(1, 4))
          add_req(REQ_POINT, rand_near(100), rand_near(100), rand_near(100), rand_full());
        if ($urandom_range(0, 4) != 0) add_req(REQ_POP, 0, 0, 0, 0);
      end
    end
    for (int i = 0; i <= DEPTH; i++) add_req(REQ_POP, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("run covered %0d checked results, %0d point transforms, %0d saturations,",
             n_checked, n_points, n_sat);
    $display("stack overflow and underflow, unknown requests and random stalls");
    if (fail_cnt == 0 && expected_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout with %0d results still expected", expected_res.size());
    $display("FAILURE");
    $finish;
  end

endmodule
